// ===== src/scc_pkg.sv =====
// Shared constants, command codes and control types for the sprite column compositor.
`default_nettype none
package scc_pkg;

   localparam int COLUMNS = 128;
   localparam int ADDR_W  = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      CMD_BLIT  = 3'd0,
      CMD_RECT  = 3'd1,
      CMD_READ  = 3'd2,
      CMD_START = 3'd3,
      CMD_END   = 3'd4
   } cmd_code_type;

   typedef struct packed {
      logic capture;   // latch request word, start store read
      logic commit;    // apply merge, update store and flag, load result
   } ctl_cmd_type;

endpackage
`default_nettype wire

// ===== src/scc_ctrl.sv =====
// Controller state machine: request acceptance, execute sequencing, result valid.
`default_nettype none
module scc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output scc_pkg::ctl_cmd_type    ctl
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl.capture  = 1'b0;
      ctl.commit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // store read data is ready; wait only for the output slot
            if (slot_free) begin
               ctl.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_EXEC)
      else $error("accepted word did not enter execute");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !rsp_valid_ff || !rsp_stall)
      else $error("result loaded over an untaken result");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.commit))
      else $error("result valid without a commit");

endmodule
`default_nettype wire

// ===== src/scc_datapath.sv =====
// Datapath: request registers, column store with valid bits, merge logic, flag, result.
`default_nettype none
module scc_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire scc_pkg::ctl_cmd_type ctl,
   input  wire logic [2:0]           req_cmd,
   input  wire logic [7:0]           req_column_x,
   input  wire logic [15:0]          req_column_word,
   input  wire logic [15:0]          req_next_word,
   input  wire logic signed [3:0]    req_vertical_offset,
   input  wire logic signed [7:0]    req_rect_top,
   input  wire logic [7:0]           req_rect_height,
   output logic [7:0]                rsp_column_byte,
   output logic                      rsp_collision
);

   logic [2:0]         cmd_ff;
   logic [7:0]         x_ff;
   logic [15:0]        word_ff;
   logic [15:0]        next_ff;
   logic signed [3:0]  voff_ff;
   logic signed [7:0]  top_ff;
   logic [7:0]         height_ff;

   logic [7:0]         mem [scc_pkg::COLUMNS];
   logic [scc_pkg::COLUMNS-1:0] valid_ff;
   logic [7:0]         rd_data_ff;
   logic               rd_valid_ff;
   logic               flag_ff;
   logic               flag_in;
   logic [7:0]         byte_ff;
   logic [7:0]         byte_in;
   logic               coll_ff;

   logic [scc_pkg::ADDR_W-1:0] rd_idx;
   logic [scc_pkg::ADDR_W-1:0] wr_idx;
   logic               in_range;
   logic [7:0]         old_byte;

   // sprite shift
   logic [3:0]         neg_amt;
   logic [15:0]        pos_fill16;
   logic [15:0]        pos_mask16;
   logic [15:0]        neg_fill16;
   logic [15:0]        neg_mask16;
   logic [7:0]         spr_fill;
   logic [7:0]         spr_mask;

   // rectangle cut
   logic [10:0]        top_ext;
   logic [10:0]        bot_sum;
   logic [10:0]        lo_raw;
   logic [3:0]         up_amt;
   logic [3:0]         lo_amt;
   logic [7:0]         rect_fill;
   logic [7:0]         rect_mask;

   logic [7:0]         fill;
   logic [7:0]         mask;
   logic [7:0]         merged;
   logic               hit;
   logic               do_write;
   logic               do_clear_one;
   logic               do_clear_all;

   assign rd_idx   = req_column_x[scc_pkg::ADDR_W-1:0];
   assign wr_idx   = x_ff[scc_pkg::ADDR_W-1:0];
   assign in_range = ({1'b0, x_ff} < 9'(scc_pkg::COLUMNS));
   assign old_byte = rd_valid_ff ? rd_data_ff : 8'h00;

   // negative offset joins the next word; -8 wraps to a zero shift
   assign neg_amt    = 4'd0 - voff_ff;
   assign pos_fill16 = {8'h00, word_ff[7:0]} << voff_ff[2:0];
   assign pos_mask16 = {8'h00, word_ff[15:8]} << voff_ff[2:0];
   assign neg_fill16 = {next_ff[7:0], word_ff[7:0]} >> neg_amt[2:0];
   assign neg_mask16 = {next_ff[15:8], word_ff[15:8]} >> neg_amt[2:0];
   assign spr_fill   = voff_ff[3] ? neg_fill16[7:0] : pos_fill16[7:0];
   assign spr_mask   = voff_ff[3] ? neg_mask16[7:0] : pos_mask16[7:0];

   assign top_ext = {{3{top_ff[7]}}, top_ff};
   assign bot_sum = top_ext + {3'b000, height_ff};
   assign lo_raw  = 11'd8 - bot_sum;

   always_comb begin
      if (top_ff[7]) begin
         up_amt = 4'd0;
      end else if (top_ff > 8'sd8) begin
         up_amt = 4'd8;
      end else begin
         up_amt = top_ff[3:0];
      end
      if (lo_raw[10]) begin
         lo_amt = 4'd0;
      end else if (lo_raw > 11'd8) begin
         lo_amt = 4'd8;
      end else begin
         lo_amt = lo_raw[3:0];
      end
   end

   assign rect_fill = (word_ff[7:0] >> lo_amt) & (word_ff[7:0] << up_amt);
   assign rect_mask = (word_ff[15:8] >> lo_amt) & (word_ff[15:8] << up_amt);

   always_comb begin
      fill         = 8'h00;
      mask         = 8'h00;
      byte_in      = 8'h00;
      do_write     = 1'b0;
      do_clear_one = 1'b0;
      do_clear_all = 1'b0;
      flag_in      = flag_ff;
      case (cmd_ff)
         scc_pkg::CMD_BLIT: begin
            fill     = spr_fill;
            mask     = spr_mask;
            do_write = in_range;
         end
         scc_pkg::CMD_RECT: begin
            fill     = rect_fill;
            mask     = rect_mask;
            do_write = in_range;
         end
         scc_pkg::CMD_READ: begin
            do_clear_one = in_range;
            byte_in      = in_range ? old_byte : 8'h00;
         end
         scc_pkg::CMD_START: begin
            flag_in = 1'b0;
         end
         scc_pkg::CMD_END: begin
            do_clear_all = 1'b1;
         end
         default: begin
            flag_in = flag_ff;
         end
      endcase
      merged = (old_byte & ~mask) | fill;
      hit    = |(old_byte & fill);
      if (do_write) begin
         byte_in = merged;
         flag_in = flag_ff | hit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff    <= req_cmd;
         x_ff      <= req_column_x;
         word_ff   <= req_column_word;
         next_ff   <= req_next_word;
         voff_ff   <= req_vertical_offset;
         top_ff    <= req_rect_top;
         height_ff <= req_rect_height;
      end
   end

   // column store: read on capture, written on commit
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
      if (ctl.commit && do_write) begin
         mem[wr_idx] <= merged;
      end
   end

   // an entry without its valid bit reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         flag_ff  <= 1'b0;
      end else if (ctl.commit) begin
         flag_ff <= flag_in;
         if (do_clear_all) begin
            valid_ff <= '0;
         end else if (do_write) begin
            valid_ff[wr_idx] <= 1'b1;
         end else if (do_clear_one) begin
            valid_ff[wr_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         byte_ff <= byte_in;
         coll_ff <= flag_in;
      end
   end

   assign rsp_column_byte = byte_ff;
   assign rsp_collision   = coll_ff;

   a_end_clears_store: assert property (@(posedge clock) disable iff (reset)
      ctl.commit && cmd_ff == scc_pkg::CMD_END |=> valid_ff == '0)
      else $error("end test left columns in the store");

   a_flag_falls_on_start: assert property (@(posedge clock) disable iff (reset)
      $fell(flag_ff) |-> $past(reset) || $past(ctl.commit && cmd_ff == scc_pkg::CMD_START))
      else $error("collision flag cleared without start test");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      ctl.commit && (cmd_ff == scc_pkg::CMD_BLIT || cmd_ff == scc_pkg::CMD_RECT)
         && flag_ff |=> flag_ff && rsp_collision)
      else $error("merge dropped the collision flag");

endmodule
`default_nettype wire

// ===== src/sprite_column_compositor.sv =====
// Top level of the sprite column compositor: controller plus datapath.
// Usage:
//   req_* carries one command word (blit sprite column, rectangle column,
//   read and clear column, start test, end test). A word is taken at a rising
//   edge with req_valid high and req_stall low.
//   rsp_* returns exactly one result per word: the new or read column byte
//   and the collision flag after the command. Taken when rsp_valid is high
//   and rsp_stall is low.
//   Each word is read from the column store on capture (registered read port),
//   then merged, written back and loaded into the result register on commit.
//   The store read-modify-write means no word is taken until the one before
//   it has committed; rsp_valid is set by the commit that loads the result.
//   While a result waits in the output register the next word is still taken
//   and read; its merge waits until the output register is free, so a stalled
//   receiver holds off requests after at most one word in flight.
//   Synchronous reset clears the flag and all column valid bits at once; the
//   store then reads as zero and a word can be taken as soon as reset is low.
//   End test clears the whole store at once through the valid bits.
`default_nettype none
module sprite_column_compositor (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_cmd,
   input  wire logic [7:0]        req_column_x,
   input  wire logic [15:0]       req_column_word,
   input  wire logic [15:0]       req_next_word,
   input  wire logic signed [3:0] req_vertical_offset,
   input  wire logic signed [7:0] req_rect_top,
   input  wire logic [7:0]        req_rect_height,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_column_byte,
   output logic                   rsp_collision
);

   scc_pkg::ctl_cmd_type ctl;

   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   scc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .req_cmd             (req_cmd),
      .req_column_x        (req_column_x),
      .req_column_word     (req_column_word),
      .req_next_word       (req_next_word),
      .req_vertical_offset (req_vertical_offset),
      .req_rect_top        (req_rect_top),
      .req_rect_height     (req_rect_height),
      .rsp_column_byte     (rsp_column_byte),
      .rsp_collision       (rsp_collision)
   );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sprite column compositor: band store, merges and collision flag.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BAND_ROWS    = 8;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 64;

   typedef struct {
      logic [2:0]        cmd;
      logic [7:0]        x;
      logic [15:0]       word;
      logic [15:0]       next;
      logic signed [3:0] voff;
      logic signed [7:0] top;
      logic [7:0]        height;
   } column_cmd_type;

   typedef struct {
      logic [7:0] column_byte;
      logic       collision;
   } column_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_cmd;
   logic [7:0]        req_column_x;
   logic [15:0]       req_column_word;
   logic [15:0]       req_next_word;
   logic signed [3:0] req_vertical_offset;
   logic signed [7:0] req_rect_top;
   logic [7:0]        req_rect_height;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [7:0]        rsp_column_byte;
   logic              rsp_collision;

   // predicted band contents and flag
   logic [7:0]        band_bytes [scc_pkg::COLUMNS];
   logic              band_overlap = 1'b0;
   column_result_type expected_results [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int rx_hold_cycles = 0;
   int rx_burst_left = 0;
   bit tx_idle_on    = 1'b0;
   bit rx_idle_on    = 1'b0;

   sprite_column_compositor dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_column_x        (req_column_x),
      .req_column_word     (req_column_word),
      .req_next_word       (req_next_word),
      .req_vertical_offset (req_vertical_offset),
      .req_rect_top        (req_rect_top),
      .req_rect_height     (req_rect_height),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_column_byte     (rsp_column_byte),
      .rsp_collision       (rsp_collision)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      foreach (band_bytes[i]) band_bytes[i] = '0;
   end

   function automatic int clamp_row(int v);
      if (v < 0) return 0;
      if (v > BAND_ROWS) return BAND_ROWS;
      return v;
   endfunction

   function automatic logic [7:0] merge_into_band(int x, logic [7:0] mask, logic [7:0] fill);
      if ((band_bytes[x] & fill) != 8'h00) band_overlap = 1'b1;
      band_bytes[x] = (band_bytes[x] & ~mask) | fill;
      return band_bytes[x];
   endfunction

   // Updates the predicted band for one word and returns its result word.
   function automatic column_result_type compose_column(column_cmd_type w);
      column_result_type r;
      int unsigned       fill_b, mask_b, next_fill, next_mask, s, up, lo;
      int                voff, top, height;
      logic [7:0]        fill, mask;
      bit                in_band;
      fill_b    = w.word[7:0];
      mask_b    = w.word[15:8];
      next_fill = w.next[7:0];
      next_mask = w.next[15:8];
      voff      = w.voff;
      top       = w.top;
      height    = w.height;
      in_band   = w.x < scc_pkg::COLUMNS;
      r.column_byte = '0;
      case (w.cmd)
         scc_pkg::CMD_BLIT: begin
            if (in_band) begin
               if (voff >= 0) begin
                  fill = 8'(fill_b << voff);
                  mask = 8'(mask_b << voff);
               end else begin
                  // offset -8 wraps to no shift, next word drops out
                  s    = (-voff) & (BAND_ROWS - 1);
                  fill = 8'((fill_b >> s) | (next_fill << (BAND_ROWS - s)));
                  mask = 8'((mask_b >> s) | (next_mask << (BAND_ROWS - s)));
               end
               r.column_byte = merge_into_band(w.x, mask, fill);
            end
         end
         scc_pkg::CMD_RECT: begin
            if (in_band) begin
               up   = clamp_row(top);
               lo   = clamp_row(BAND_ROWS - (top + height));
               fill = 8'((fill_b >> lo) & (fill_b << up));
               mask = 8'((mask_b >> lo) & (mask_b << up));
               r.column_byte = merge_into_band(w.x, mask, fill);
            end
         end
         scc_pkg::CMD_READ: begin
            if (in_band) begin
               r.column_byte = band_bytes[w.x];
               band_bytes[w.x] = '0;
            end
         end
         scc_pkg::CMD_START: band_overlap = 1'b0;
         scc_pkg::CMD_END: foreach (band_bytes[i]) band_bytes[i] = '0;
         default: ;
      endcase
      r.collision = band_overlap;
      return r;
   endfunction

   function automatic column_cmd_type make_word(logic [2:0] cmd, logic [7:0] x,
                                                logic [15:0] word, logic [15:0] next,
                                                logic signed [3:0] voff,
                                                logic signed [7:0] top, logic [7:0] height);
      column_cmd_type w;
      w.cmd    = cmd;
      w.x      = x;
      w.word   = word;
      w.next   = next;
      w.voff   = voff;
      w.top    = top;
      w.height = height;
      return w;
   endfunction

   // Mostly merges on a few hot columns so overlaps and reads of live data are common.
   function automatic column_cmd_type random_word();
      column_cmd_type w;
      int             pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) w.cmd = scc_pkg::CMD_BLIT;
      else if (pick < 75) w.cmd = scc_pkg::CMD_RECT;
      else if (pick < 88) w.cmd = scc_pkg::CMD_READ;
      else if (pick < 93) w.cmd = scc_pkg::CMD_START;
      else if (pick < 96) w.cmd = scc_pkg::CMD_END;
      else w.cmd = 3'(scc_pkg::CMD_END) + 3'($urandom_range(1, 3));
      pick = $urandom_range(0, 19);
      if (pick < 10) w.x = 8'($urandom_range(0, 7));
      else if (pick < 17) w.x = 8'($urandom_range(0, scc_pkg::COLUMNS - 1));
      else w.x = 8'($urandom_range(scc_pkg::COLUMNS, 255));
      w.word = 16'($urandom);
      w.next = 16'($urandom);
      w.voff = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) begin
         w.top    = 8'($urandom_range(0, 12) - 3);
         w.height = 8'($urandom_range(0, 10));
      end else begin
         w.top    = 8'($urandom_range(0, 255));
         w.height = 8'($urandom_range(0, 255));
      end
      return w;
   endfunction

   task automatic send_word(column_cmd_type w);
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= w.cmd;
      req_column_x        <= w.x;
      req_column_word     <= w.word;
      req_next_word       <= w.next;
      req_vertical_offset <= w.voff;
      req_rect_top        <= w.top;
      req_rect_height     <= w.height;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(compose_column(w));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_blit_shifts();
      send_word(make_word(scc_pkg::CMD_BLIT, 8'd0, 16'hFF81, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'd0, 16'h00FF, 16'hFFFF, 4'sd7, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'(scc_pkg::COLUMNS - 1), 16'hF00F, 16'hA55A,
                          -4'sd1, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'(scc_pkg::COLUMNS - 1), 16'h0FF0, 16'h5AA5,
                          -4'sd7, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'(scc_pkg::COLUMNS - 1), 16'hFFFF, 16'hFFFF,
                          -4'sd8, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'(scc_pkg::COLUMNS), 16'hFFFF, 16'hFFFF,
                          4'sd3, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'hFF, 16'hFFFF, 16'hFFFF, -4'sd2, 8'sd0, 8'd0));
   endtask

   task automatic test_rect_cuts();
      send_word(make_word(scc_pkg::CMD_RECT, 8'd1, 16'hFFFF, 16'h0000, 4'sd0, -8'sd128,
                          8'd255));
      send_word(make_word(scc_pkg::CMD_RECT, 8'd1, 16'hFFFF, 16'hFFFF, 4'sd0, 8'sd127, 8'd255));
      send_word(make_word(scc_pkg::CMD_RECT, 8'd1, 16'hFFFF, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_RECT, 8'd3, 16'h3CFF, 16'h0000, 4'sd0, 8'sd2, 8'd3));
      send_word(make_word(scc_pkg::CMD_RECT, 8'd3, 16'hFF0F, 16'h0000, 4'sd0, -8'sd3, 8'd5));
      send_word(make_word(scc_pkg::CMD_RECT, 8'd3, 16'h00F0, 16'h0000, 4'sd0, 8'sd5, 8'd255));
      send_word(make_word(scc_pkg::CMD_RECT, 8'(scc_pkg::COLUMNS), 16'hFFFF, 16'h0000,
                          4'sd0, 8'sd0, 8'd8));
   endtask

   task automatic test_read_and_flags();
      send_word(make_word(scc_pkg::CMD_READ, 8'd0, 16'h0000, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_READ, 8'd0, 16'hFFFF, 16'hFFFF, -4'sd8, -8'sd1,
                          8'd255));
      send_word(make_word(scc_pkg::CMD_READ, 8'(scc_pkg::COLUMNS - 1), 16'h0000, 16'h0000,
                          4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_READ, 8'hFF, 16'h0000, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_START, 8'd0, 16'h0000, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'd2, 16'h00C3, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_BLIT, 8'd2, 16'h0001, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_END, 8'd2, 16'h0000, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      send_word(make_word(scc_pkg::CMD_READ, 8'd2, 16'h0000, 16'h0000, 4'sd0, 8'sd0, 8'd0));
      for (int c = scc_pkg::CMD_END + 1; c < (1 << $bits(req_cmd)); c++)
         send_word(make_word(3'(c), 8'd3, 16'hFFFF, 16'hFFFF, 4'sd1, 8'sd0, 8'd8));
   endtask

   task automatic test_random_mix(int words);
      int issued;
      issued = 0;
      while (issued < words) begin
         if (issued % 40 == 0) begin
            tx_idle_on = 1'($urandom_range(0, 1));
            rx_idle_on = 1'($urandom_range(0, 1));
         end
         send_word(random_word());
         issued++;
      end
   endtask

   // Receiver holds off long enough that the block backs up into req_stall.
   task automatic test_backpressure();
      tx_idle_on     = 1'b0;
      rx_hold_cycles = HOLD_CYCLES;
      repeat (20) send_word(random_word());
      wait_for_drain();
   endtask

   task automatic test_steady_stream(int words);
      tx_idle_on    = 1'b0;
      rx_idle_on    = 1'b0;
      rx_burst_left = 0;
      repeat (words) send_word(random_word());
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rx_hold_cycles--;
         end else if (rx_burst_left > 0) begin
            rsp_stall <= 1'b1;
            rx_burst_left--;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            rx_burst_left = $urandom_range(0, 9);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      column_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            $error("result word with none pending: column_byte %02h collision %0b",
                   rsp_column_byte, rsp_collision);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_column_byte !== want.column_byte) begin
               $error("column_byte: expected %02h, actual %02h",
                      want.column_byte, rsp_column_byte);
               error_count++;
            end
            if (rsp_collision !== want.collision) begin
               $error("collision: expected %0b, actual %0b", want.collision, rsp_collision);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sprite_column_compositor verification failed");
         $finish;
      end
   end

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_cmd             <= scc_pkg::CMD_BLIT;
      req_column_x        <= '0;
      req_column_word     <= '0;
      req_next_word       <= '0;
      req_vertical_offset <= '0;
      req_rect_top        <= '0;
      req_rect_height     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_blit_shifts();
      test_rect_cuts();
      test_read_and_flags();
      wait_for_drain();
      test_random_mix(200);
      wait_for_drain();
      test_backpressure();
      test_random_mix(220);
      wait_for_drain();
      test_steady_stream(60);
      wait_for_drain();

      if (error_count == 0) begin
         $display("sprite_column_compositor verification clean");
      end else begin
         $display("sprite_column_compositor verification failed");
      end
      $finish;
   end

endmodule
